### hdl/dtms_pkg.sv
package dtms_pkg;

    localparam int unsigned ACC_W  = 33;
    localparam int unsigned FRAC_W = 10;
    localparam int unsigned CNT_W  = 2;
    localparam int unsigned MS_W   = 32;
    localparam int unsigned PROD_W = 43;

    localparam logic [ACC_W-1:0]  SAT33         = {ACC_W{1'b1}};
    localparam logic [MS_W-1:0]   SAT32         = {MS_W{1'b1}};
    localparam logic [ACC_W-1:0]  PLAIN_MS_MIN  = 33'd10000;
    localparam logic [PROD_W-1:0] MS_PER_SEC    = 43'd1000;
    localparam logic [39:0]       SEC_PER_MIN   = 40'd60;
    localparam logic [CNT_W-1:0]  FRAC_DIGITS   = 2'd3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [ACC_W-1:0]  seconds;
        logic [ACC_W-1:0]  whole;
        logic [FRAC_W-1:0] frac;
        logic [CNT_W-1:0]  count;
        logic              digit;
        logic              separator;
        logic              error;
    } t_snap;

    typedef struct packed {
        logic [ACC_W-1:0]  mant;
        logic [FRAC_W-1:0] addend;
        logic              scale;
        logic              bad;
    } t_scale;

    function automatic logic [ACC_W-1:0] sat_min60(input logic [ACC_W-1:0] secs,
                                                    input logic [ACC_W-1:0] seg);
        logic [39:0] sum;
        sum = {7'd0, secs} * SEC_PER_MIN + {7'd0, seg};
        sat_min60 = (|sum[39:ACC_W]) ? SAT33 : sum[ACC_W-1:0];
    endfunction

endpackage

### hdl/dtms_char_stage.sv
module dtms_char_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    input  logic            i_empty,
    input  logic            i_snap_ready,
    output logic            o_snap_valid,
    output dtms_pkg::t_snap o_snap
);
    import dtms_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              r_last;
    logic              r_empty;

    logic [ACC_W-1:0]  r_st,    n_st;
    logic [ACC_W-1:0]  r_seg,   n_seg;
    logic [FRAC_W-1:0] r_frac,  n_frac;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic              r_digit, n_digit;
    logic              r_fin,   n_fin;
    logic              r_sep,   n_sep;
    logic              r_err,   n_err;

    logic [3:0]        w_d;
    logic [36:0]       w_seg10;
    logic [13:0]       w_frac10;
    logic              w_proc;

    assign w_d      = r_char[3:0];
    assign w_seg10  = {4'd0, r_seg} * 37'd10 + {33'd0, w_d};
    assign w_frac10 = {4'd0, r_frac} * 14'd10 + {10'd0, w_d};

    always_comb begin
        n_st    = r_st;
        n_seg   = r_seg;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_digit = r_digit;
        n_fin   = r_fin;
        n_sep   = r_sep;
        n_err   = r_err;
        if (!r_empty && !r_err) begin
            if (r_char == CH_COLON) begin
                n_sep = 1'b1;
                if (!r_digit || r_fin) begin
                    n_err = 1'b1;
                end else begin
                    n_st    = sat_min60(r_st, r_seg);
                    n_seg   = '0;
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_digit = 1'b0;
                    n_fin   = 1'b0;
                end
            end else if (r_char == CH_DOT || r_char == CH_COMMA) begin
                n_sep = 1'b1;
                if (r_fin) begin
                    n_err = 1'b1;
                end else begin
                    n_fin = 1'b1;
                end
            end else if (r_char >= CH_ZERO && r_char <= CH_NINE) begin
                n_digit = 1'b1;
                if (!r_fin) begin
                    n_seg = (|w_seg10[36:ACC_W]) ? SAT33 : w_seg10[ACC_W-1:0];
                end else if (r_cnt < FRAC_DIGITS) begin
                    n_frac = w_frac10[FRAC_W-1:0];
                    n_cnt  = r_cnt + 2'd1;
                end
            end else begin
                n_err = 1'b1;
            end
        end
    end

    assign w_proc       = r_in_valid && (!r_last || i_snap_ready);
    assign o_ready      = !r_in_valid || w_proc;
    assign o_snap_valid = r_in_valid && r_last;

    always_comb begin
        o_snap.seconds   = n_st;
        o_snap.whole     = n_seg;
        o_snap.frac      = n_frac;
        o_snap.count     = n_cnt;
        o_snap.digit     = n_digit;
        o_snap.separator = n_sep;
        o_snap.error     = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char  <= i_char;
            r_last  <= i_last;
            r_empty <= i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proc && r_last)) begin
            r_st    <= '0;
            r_seg   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_digit <= 1'b0;
            r_fin   <= 1'b0;
            r_sep   <= 1'b0;
            r_err   <= 1'b0;
        end else if (w_proc) begin
            r_st    <= n_st;
            r_seg   <= n_seg;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
            r_digit <= n_digit;
            r_fin   <= n_fin;
            r_sep   <= n_sep;
            r_err   <= n_err;
        end
    end

endmodule

### hdl/dtms_finish_stage.sv
module dtms_finish_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dtms_pkg::t_snap  i_snap,
    input  logic             i_c_ready,
    output logic             o_c_valid,
    output dtms_pkg::t_scale o_c
);
    import dtms_pkg::*;

    logic              r_b_valid;
    t_snap             r_b;
    logic [ACC_W-1:0]  w_secs;
    logic [FRAC_W-1:0] w_frac;

    assign o_c_valid = r_b_valid;
    assign o_ready   = !r_b_valid || i_c_ready;
    assign w_secs    = sat_min60(r_b.seconds, r_b.whole);

    // pad the fraction out to three digits
    always_comb begin
        case (r_b.count)
            2'd1:    w_frac = r_b.frac * 10'd100;
            2'd2:    w_frac = r_b.frac * 10'd10;
            2'd3:    w_frac = r_b.frac;
            default: w_frac = '0;
        endcase
    end

    always_comb begin
        o_c.mant   = '0;
        o_c.addend = '0;
        o_c.scale  = 1'b0;
        o_c.bad    = 1'b0;
        if (r_b.error) begin
            o_c.bad = 1'b1;
        end else if (!r_b.separator) begin
            if (r_b.digit) begin
                o_c.mant  = r_b.whole;
                o_c.scale = r_b.whole < PLAIN_MS_MIN;
            end
        end else if (!r_b.digit) begin
            o_c.bad = 1'b1;
        end else begin
            o_c.mant   = w_secs;
            o_c.addend = w_frac;
            o_c.scale  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_ready) begin
            r_b_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_b <= i_snap;
        end
    end

endmodule

### hdl/dtms_scale_stage.sv
module dtms_scale_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dtms_pkg::t_scale i_c,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_ms,
    output logic             o_bad
);
    import dtms_pkg::*;

    logic              r_c_valid;
    t_scale            r_c;
    logic              r_out_valid;
    logic [MS_W-1:0]   r_out_ms;
    logic              r_out_bad;
    logic              w_out_en;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_sum;
    logic [MS_W-1:0]   n_ms;

    assign w_out_en = !r_out_valid || i_ready;
    assign o_ready  = !r_c_valid || w_out_en;

    assign w_prod = r_c.scale ? {10'd0, r_c.mant} * MS_PER_SEC : {10'd0, r_c.mant};
    assign w_sum  = w_prod + {33'd0, r_c.addend};

    always_comb begin
        if (r_c.bad) begin
            n_ms = '0;
        end else if (|w_sum[PROD_W-1:MS_W]) begin
            n_ms = SAT32;
        end else begin
            n_ms = w_sum[MS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_c_valid <= i_valid;
            end
            if (w_out_en) begin
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_c <= i_c;
        end
        if (w_out_en && r_c_valid) begin
            r_out_ms  <= n_ms;
            r_out_bad <= r_c.bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ms    = r_out_ms;
    assign o_bad   = r_out_bad;

endmodule

### hdl/duration_text_to_milliseconds.sv
// Duration string parser: characters in, milliseconds out.
// Slave channel carries one character per request: tdata is the ASCII code,
// tlast marks the last request of a string, tuser flags a request without a
// character (an empty string is one request with tuser and tlast high).
// Master channel gives one result per string: tdata is the duration in
// milliseconds, saturated to 2^32-1; tuser flags a malformed string, in
// which case tdata is 0. Requests without tlast give no result.
// Throughput: one request per cycle, no gap between strings, while the master
// side takes results. Results pass four register stages: input and parse
// state, segment combine, millisecond scale, output register.
// Reset clears the parse state and empties all stages; the block can take
// a request in the first cycle after reset.
// When the master side stalls, the stages behind it fill, then tready on the
// slave side drops once a last request waits at the input; nothing is lost.
module duration_text_to_milliseconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // is_last
    input  logic        i_s_tuser,   // [0] is_empty
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] time_ms
    output logic        o_m_tuser    // [0] malformed
);
    import dtms_pkg::*;

    logic   w_snap_valid;
    logic   w_snap_ready;
    t_snap  w_snap;
    logic   w_c_valid;
    logic   w_c_ready;
    t_scale w_c;

    dtms_char_stage u_char (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_char       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_empty      (i_s_tuser),
        .i_snap_ready (w_snap_ready),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap)
    );

    dtms_finish_stage u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_snap_valid),
        .o_ready   (w_snap_ready),
        .i_snap    (w_snap),
        .i_c_ready (w_c_ready),
        .o_c_valid (w_c_valid),
        .o_c       (w_c)
    );

    dtms_scale_stage u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_c     (w_c),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_ms    (o_m_tdata),
        .o_bad   (o_m_tuser)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dtms_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 730;
    localparam int TAIL_ITEMS   = 120;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       empty;
    } t_char_req;

    typedef struct {
        logic [31:0] ms;
        logic        bad;
    } t_duration;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;   // [7:0] char_code
    logic        i_s_tlast = 1'b0;   // is_last
    logic        i_s_tuser = 1'b0;   // [0] is_empty
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;          // [31:0] time_ms
    logic        o_m_tuser;          // [0] malformed

    t_char_req   char_queue[$];
    t_duration   durations_due[$];
    logic [7:0]  text_buf[$];
    t_char_req   on_bus;

    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          rx_stall = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          idle_mode = 1'b1;

    // parse state mirror
    logic [32:0] secs_acc;
    logic [32:0] seg_whole;
    logic [9:0]  frac_val;
    logic [1:0]  frac_cnt;
    bit          digit_seen;
    bit          frac_open;
    bit          sep_seen;
    bit          err_seen;

    duration_text_to_milliseconds i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [32:0] clamp33(input logic [63:0] v);
        return (v > 64'h1_FFFF_FFFF) ? SAT33 : v[32:0];
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
    endfunction

    function automatic logic [32:0] fold_minutes();
        return clamp33({31'd0, secs_acc} * 64'd60 + {31'd0, seg_whole});
    endfunction

    task automatic clear_segment();
        seg_whole   = '0;
        frac_val    = '0;
        frac_cnt    = '0;
        digit_seen  = 1'b0;
        frac_open   = 1'b0;
    endtask

    task automatic clear_parse();
        secs_acc = '0;
        clear_segment();
        sep_seen = 1'b0;
        err_seen = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] code);
        logic [3:0] digit;
        if (err_seen)
            return;
        if (code == CH_COLON) begin
            sep_seen = 1'b1;
            if (!digit_seen || frac_open) begin
                err_seen = 1'b1;
                return;
            end
            secs_acc = fold_minutes();
            clear_segment();
        end else if (code == CH_DOT || code == CH_COMMA) begin
            sep_seen = 1'b1;
            if (frac_open)
                err_seen = 1'b1;
            else
                frac_open = 1'b1;
        end else if (code >= CH_ZERO && code <= CH_NINE) begin
            digit = 4'(code - CH_ZERO);
            digit_seen = 1'b1;
            if (!frac_open) begin
                seg_whole = clamp33({31'd0, seg_whole} * 64'd10 + 64'(digit));
            end else if (frac_cnt < FRAC_DIGITS) begin
                frac_val = 10'(frac_val * 10 + digit);
                frac_cnt = frac_cnt + 2'd1;
            end
        end else begin
            err_seen = 1'b1;
        end
    endtask

    task automatic close_string();
        logic [63:0] ms;
        logic [63:0] frac;
        t_duration   d;
        int          n;
        ms = '0;
        d.bad = 1'b0;
        if (err_seen) begin
            d.bad = 1'b1;
        end else if (!sep_seen) begin
            if (digit_seen)
                ms = (seg_whole >= PLAIN_MS_MIN) ? 64'(seg_whole)
                                                 : {31'd0, seg_whole} * 64'd1000;
        end else if (!digit_seen) begin
            d.bad = 1'b1;
        end else begin
            frac = 64'(frac_val);
            for (n = int'(frac_cnt); n < int'(FRAC_DIGITS); n++)
                frac = frac * 10;
            ms = {31'd0, fold_minutes()} * 64'd1000 + frac;
        end
        d.ms = d.bad ? 32'd0 : clamp32(ms);
        durations_due.push_back(d);
        clear_parse();
    endtask

    task automatic take_request(input t_char_req r);
        if (!r.empty)
            parse_char(r.code);
        if (r.last)
            close_string();
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [31:0] ms, input logic bad);
        t_duration d;
        results_seen++;
        if (durations_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result ms=%0d malformed=%0b", ms, bad));
            return;
        end
        d = durations_due.pop_front();
        if (ms !== d.ms)
            flag_mismatch($sformatf("time_ms %0d, want %0d", ms, d.ms));
        if (bad !== d.bad)
            flag_mismatch($sformatf("malformed %0b, want %0b", bad, d.bad));
    endtask

    // stimulus building
    task automatic queue_text(input int bubble_pct, input bit end_empty);
        t_char_req r;
        if (text_buf.size() == 0) begin
            r = '{code: 8'($urandom_range(0, 255)), last: 1'b1, empty: 1'b1};
            char_queue.push_back(r);
            return;
        end
        foreach (text_buf[i]) begin
            if ($urandom_range(0, 99) < bubble_pct) begin
                r = '{code: 8'($urandom_range(0, 255)), last: 1'b0, empty: 1'b1};
                char_queue.push_back(r);
            end
            r = '{code: text_buf[i], last: (i == text_buf.size() - 1) && !end_empty,
                  empty: 1'b0};
            char_queue.push_back(r);
        end
        if (end_empty) begin
            r = '{code: 8'($urandom_range(0, 255)), last: 1'b1, empty: 1'b1};
            char_queue.push_back(r);
        end
        text_buf.delete();
    endtask

    task automatic queue_string(input string s, input int bubble_pct, input bit end_empty);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        queue_text(bubble_pct, end_empty);
    endtask

    task automatic add_digits(input int n);
        repeat (n) text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    function automatic int digit_span();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(8, 14);
        return $urandom_range(1, 5);
    endfunction

    task automatic add_random_string();
        int kind;
        int segs;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 2) begin
            queue_text(0, 1'b0);
            return;
        end
        if (kind < 32) begin
            add_digits(digit_span());
        end else begin
            segs = $urandom_range(1, 4);
            for (int s = 0; s < segs; s++) begin
                if (s > 0)
                    text_buf.push_back(CH_COLON);
                add_digits(($urandom_range(0, 9) == 0) ? digit_span() : $urandom_range(1, 2));
            end
            if ($urandom_range(0, 9) < 7 || segs == 1) begin
                text_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
                add_digits($urandom_range(0, 5));
            end
        end
        if (kind >= 82) begin
            pos = $urandom_range(0, text_buf.size());
            case ($urandom_range(0, 2))
                0: text_buf.insert(pos, 8'($urandom_range(0, 255)));
                1: text_buf.insert(pos, ($urandom_range(0, 1) ? CH_COLON : CH_DOT));
                default: begin
                    if (text_buf.size() > 1)
                        text_buf.delete($urandom_range(0, text_buf.size() - 1));
                end
            endcase
        end
        queue_text(($urandom_range(0, 3) == 0) ? 15 : 0, $urandom_range(0, 9) == 0);
    endtask

    initial begin
        int target;
        clear_parse();

        queue_string("", 0, 1'b0);
        queue_string("0", 0, 1'b0);
        queue_string("9999", 0, 1'b0);
        queue_string("10000", 0, 1'b0);
        queue_string("4294967", 0, 1'b0);
        queue_string("4294968", 0, 1'b0);
        queue_string("99999999999", 0, 1'b0);
        queue_string("1:30", 0, 1'b0);
        queue_string("01:02:03.5", 0, 1'b0);
        queue_string("1,25", 0, 1'b0);
        queue_string("1.23456", 0, 1'b0);
        queue_string("5.", 0, 1'b0);
        queue_string(".", 0, 1'b0);
        queue_string(":5", 0, 1'b0);
        queue_string("5:", 0, 1'b0);
        queue_string("1.2:3", 0, 1'b0);
        queue_string("1..2", 0, 1'b0);
        queue_string("1.2,3", 0, 1'b0);
        queue_string(" 7", 0, 1'b0);
        queue_string("-5", 0, 1'b0);
        queue_string("1a2", 0, 1'b0);
        queue_string("99999999999:59:59.999", 0, 1'b0);
        queue_string("12", 50, 1'b1);
        text_buf.push_back(8'h00);
        queue_text(0, 1'b0);
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h31);
        queue_text(0, 1'b0);

        target = char_queue.size() + RANDOM_ITEMS;
        while (char_queue.size() < target)
            add_random_string();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_queue.size() != 0 || i_s_tvalid || durations_due.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (durations_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", durations_due.size()));
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                take_request(on_bus);
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    on_bus = char_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= on_bus.code;
                    i_s_tlast  <= on_bus.last;
                    i_s_tuser  <= on_bus.empty;
                    if (idle_mode && hold_left == 0 && char_queue.size() > TAIL_ITEMS
                            && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                check_result(o_m_tdata, o_m_tuser);
            if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else if (idle_mode && char_queue.size() > TAIL_ITEMS
                         && $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(0, 9);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (hold_left == 0);
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
            idle_mode <= ($urandom_range(0, 3) != 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
